>>> sv/u2u8_pkg.sv
// ============================================================================
// u2u8_pkg - UTF-16 to UTF-8 converter package
// Shared constants and the queue entry type for the converter.
// ============================================================================
package u2u8_pkg;

    localparam logic [15:0] LEAD_LO  = 16'hD800;
    localparam logic [15:0] LEAD_HI  = 16'hDBFF;
    localparam logic [15:0] TRAIL_LO = 16'hDC00;
    localparam logic [15:0] TRAIL_HI = 16'hDFFF;
    localparam logic [15:0] TWO_BYTE_MIN   = 16'h0080;
    localparam logic [15:0] THREE_BYTE_MIN = 16'h0800;

    // Plane offset (0x10000) added above the ten low trail bits
    localparam logic [10:0] PLANE_OFFSET_HI = 11'h040;

    localparam logic [7:0] PREFIX_FOUR  = 8'hF0;
    localparam logic [7:0] PREFIX_THREE = 8'hE0;
    localparam logic [7:0] PREFIX_TWO   = 8'hC0;
    localparam logic [7:0] PREFIX_CONT  = 8'h80;

    // Index of the final byte of a run
    localparam logic [1:0] LAST_IDX_ONE   = 2'd0;
    localparam logic [1:0] LAST_IDX_TWO   = 2'd1;
    localparam logic [1:0] LAST_IDX_THREE = 2'd2;
    localparam logic [1:0] LAST_IDX_FOUR  = 2'd3;

    // One encoded run: bytes[0] leaves first
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
    } entry_t;

endpackage

>>> sv/u2u8_if.sv
// ============================================================================
// u2u8_if - converter stream interfaces
// Valid/ready channels for code units in and UTF-8 bytes out.
// ============================================================================
interface u2u8_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        last_unit;

    modport source (output valid, output code_unit, output last_unit, input ready);
    modport sink   (input valid, input code_unit, input last_unit, output ready);
endinterface

interface u2u8_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, output out_byte, output last_byte, input ready);
    modport sink   (input valid, input out_byte, input last_byte, output ready);
endinterface

>>> sv/u2u8_front.sv
// ============================================================================
// u2u8_front - converter front end
// Accepts code units, tracks the pending lead surrogate and encodes each unit
// other than a lead or lone trail into a one- to four-byte run for the queue.
// ============================================================================
module u2u8_front (
    input  logic              clk,
    input  logic              rst_n,
    u2u8_unit_if.sink         unit_chan,
    input  logic              full,
    output logic              push,
    output u2u8_pkg::entry_t  push_entry
);
    import u2u8_pkg::*;

    logic        lead_pending_reg;
    logic        lead_pending_next;
    logic [9:0]  lead_bits_reg;
    logic [9:0]  lead_bits_next;
    logic        accept;
    logic        is_lead;
    logic        is_trail;
    logic [20:0] cp;
    logic [15:0] u;
    entry_t      entry;

    assign unit_chan.ready = !full;
    assign accept = unit_chan.valid && unit_chan.ready;
    assign u = unit_chan.code_unit;

    always_comb
    begin
        is_lead  = (u inside {[LEAD_LO:LEAD_HI]});
        is_trail = (u inside {[TRAIL_LO:TRAIL_HI]});
        cp = {({1'b0, lead_bits_reg} + PLANE_OFFSET_HI), u[9:0]};

        entry.bytes    = '0;
        entry.last_idx = LAST_IDX_ONE;
        if (is_trail)
        begin
            entry.bytes[0] = PREFIX_FOUR | {5'b0, cp[20:18]};
            entry.bytes[1] = PREFIX_CONT | {2'b0, cp[17:12]};
            entry.bytes[2] = PREFIX_CONT | {2'b0, cp[11:6]};
            entry.bytes[3] = PREFIX_CONT | {2'b0, cp[5:0]};
            entry.last_idx = LAST_IDX_FOUR;
        end
        else if (u >= THREE_BYTE_MIN)
        begin
            entry.bytes[0] = PREFIX_THREE | {4'b0, u[15:12]};
            entry.bytes[1] = PREFIX_CONT | {2'b0, u[11:6]};
            entry.bytes[2] = PREFIX_CONT | {2'b0, u[5:0]};
            entry.last_idx = LAST_IDX_THREE;
        end
        else if (u >= TWO_BYTE_MIN)
        begin
            entry.bytes[0] = PREFIX_TWO | {3'b0, u[10:6]};
            entry.bytes[1] = PREFIX_CONT | {2'b0, u[5:0]};
            entry.last_idx = LAST_IDX_TWO;
        end
        else
        begin
            entry.bytes[0] = {1'b0, u[6:0]};
        end

        // Leads and lone trails make no run
        push = accept && !is_lead && !(is_trail && !lead_pending_reg);

        lead_pending_next = lead_pending_reg;
        lead_bits_next    = lead_bits_reg;
        if (accept)
        begin
            if (is_lead)
            begin
                if (!lead_pending_reg)
                begin
                    lead_pending_next = 1'b1;
                    lead_bits_next    = u[9:0];
                end
                else
                begin
                    lead_pending_next = 1'b0;
                end
            end
            else if (is_trail)
            begin
                lead_pending_next = 1'b0;
            end
            if (unit_chan.last_unit)
            begin
                lead_pending_next = 1'b0;
            end
        end
    end

    assign push_entry = entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_pending_reg <= 1'b0;
            lead_bits_reg    <= '0;
        end
        else
        begin
            lead_pending_reg <= lead_pending_next;
            lead_bits_reg    <= lead_bits_next;
        end
    end

    a_last_clears_lead: assert property (@(posedge clk) disable iff (!rst_n)
        accept && unit_chan.last_unit |=> !lead_pending_reg)
        else $error("pending lead survived a last unit");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("run pushed into a full queue");

    a_trail_pairs_lead: assert property (@(posedge clk) disable iff (!rst_n)
        push && is_trail |-> lead_pending_reg)
        else $error("four-byte run without a pending lead");

endmodule

>>> sv/u2u8_queue.sv
// ============================================================================
// u2u8_queue - run queue
// Small register FIFO of encoded runs between front and back end.
// ============================================================================
module u2u8_queue #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  u2u8_pkg::entry_t  push_entry,
    output logic              full,
    input  logic              pop,
    output u2u8_pkg::entry_t  head,
    output logic              empty
);
    import u2u8_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t        mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a push");

endmodule

>>> sv/u2u8_back.sv
// ============================================================================
// u2u8_back - converter back end
// Walks the head run into a registered output stage, one byte per free cycle.
// ============================================================================
module u2u8_back (
    input  logic              clk,
    input  logic              rst_n,
    input  u2u8_pkg::entry_t  head,
    input  logic              empty,
    output logic              pop,
    u2u8_byte_if.source       byte_chan
);
    import u2u8_pkg::*;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic [1:0] byte_idx_reg;
    logic [1:0] byte_idx_next;
    logic       load;
    logic       final_byte;

    // Output stage free: advance to the next byte of the head run
    assign load       = !out_valid_reg || byte_chan.ready;
    assign final_byte = (byte_idx_reg == head.last_idx);
    assign pop        = load && !empty && final_byte;

    always_comb
    begin
        byte_idx_next = byte_idx_reg;
        if (load && !empty)
        begin
            byte_idx_next = final_byte ? '0 : byte_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            byte_idx_reg  <= '0;
        end
        else
        begin
            byte_idx_reg <= byte_idx_next;
            if (load)
            begin
                out_valid_reg <= !empty;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && !empty)
        begin
            out_byte_reg <= head.bytes[byte_idx_reg];
            out_last_reg <= final_byte;
        end
    end

    assign byte_chan.valid     = out_valid_reg;
    assign byte_chan.out_byte  = out_byte_reg;
    assign byte_chan.last_byte = out_last_reg;

    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> byte_idx_reg <= head.last_idx)
        else $error("byte index past end of run");

    a_idx_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> byte_idx_reg == '0)
        else $error("byte index left mid-run with queue empty");

    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg && out_last_reg)
        else $error("run retired without a final byte");

endmodule

>>> sv/utf16_to_utf8_converter.sv
// ============================================================================
// utf16_to_utf8_converter - UTF-16 to UTF-8 transcoder
// One UTF-16 code unit in per request, its UTF-8 bytes out one per request.
// ============================================================================
//
//  Channel     Dir   Payload                         Accepted when
//  ---------   ---   -----------------------------   -------------------
//  unit_chan   in    code_unit[15:0], last_unit      valid && ready
//  byte_chan   out   out_byte[7:0], last_byte        valid && ready
//
//  A unit produces 0 to 4 bytes (4 for the trail of a surrogate pair); the
//  back end emits one byte per cycle while byte_chan is not stalled.
//  A lead or a dropped trail produces no bytes.
//  The byte output port sets the throughput.
//  A unit's first byte is written into the run queue when the unit is
//  accepted, then into the output register that drives byte_chan.
//  Reset (rst_n low, asynchronous) empties the queue, drops any pending lead
//  and clears the output valid.
//  A stall on byte_chan holds the output byte; the front end keeps accepting
//  units until the run queue (QUEUE_DEPTH runs) fills.
//
module utf16_to_utf8_converter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    u2u8_unit_if.sink   unit_chan,
    u2u8_byte_if.source byte_chan
);
    import u2u8_pkg::*;

    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    entry_t push_entry;
    entry_t head;

    // Front end: classify units, track the lead, encode runs
    u2u8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .unit_chan  (unit_chan),
        .full       (full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decouple front and back so each side can stall on its own
    u2u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    // Back end: serialize the head run into bytes
    u2u8_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .byte_chan (byte_chan)
    );

endmodule

>>> dv/tb_utf16_to_utf8_converter.sv
// ============================================================================
// tb_utf16_to_utf8_converter - self-checking bench for the UTF-16 to UTF-8
// converter
// Drives code units into the converter and checks every UTF-8 byte it emits
// against a transcoder model kept in a small scoreboard. Runs a directed set
// of edge and surrogate cases, then random strings of surrogate pairs and
// noise under four sender/receiver idle mixes and one long receiver hold.
// ============================================================================
module tb_utf16_to_utf8_converter;
    import u2u8_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 16;

    // Stimulus categories for random strings
    typedef enum int {
        KIND_ASCII,
        KIND_TWO,
        KIND_THREE,
        KIND_PAIR,
        KIND_LONE_TRAIL,
        KIND_LONE_LEAD,
        KIND_DOUBLE_LEAD
    } unit_kind_t;

    // One expected UTF-8 byte
    typedef struct packed {
        logic [7:0] octet;
        logic       is_last;
    } utf8_out_t;

    // ------------------------------------------------------------------------
    // Transcoder model and byte store
    // ------------------------------------------------------------------------
    class utf8_scoreboard;
        utf8_out_t   bytes_due[$];
        bit          lead_held;
        logic [9:0]  lead_low;
        int          n_units;
        int          n_dropped;
        int          n_pairs;
        int          n_bytes;
        int          n_errors;

        function new();
            lead_held = 1'b0;
            lead_low  = '0;
            n_units   = 0;
            n_dropped = 0;
            n_pairs   = 0;
            n_bytes   = 0;
            n_errors  = 0;
        endfunction

        function void push_byte(logic [7:0] octet, logic is_last);
            utf8_out_t entry;
            entry.octet   = octet;
            entry.is_last = is_last;
            bytes_due.push_back(entry);
        endfunction

        // Note an accepted code unit and queue the bytes it must produce
        function void note_unit(logic [15:0] unit, logic end_of_string);
            logic [20:0] cp;
            n_units++;
            if (unit >= LEAD_LO && unit <= LEAD_HI) begin
                // A second lead clears the held one and is itself dropped
                if (!lead_held) begin
                    lead_held = 1'b1;
                    lead_low  = unit[9:0];
                end
                else
                begin
                    lead_held = 1'b0;
                    n_dropped++;
                end
            end
            else if (unit >= TRAIL_LO && unit <= TRAIL_HI) begin
                if (lead_held) begin
                    cp = 21'h010000 + 21'({lead_low, unit[9:0]});
                    lead_held = 1'b0;
                    n_pairs++;
                    push_byte(PREFIX_FOUR + 8'(cp[20:18]), 1'b0);
                    push_byte(PREFIX_CONT + 8'(cp[17:12]), 1'b0);
                    push_byte(PREFIX_CONT + 8'(cp[11:6]), 1'b0);
                    push_byte(PREFIX_CONT + 8'(cp[5:0]), 1'b1);
                end
                else
                begin
                    n_dropped++;
                end
            end
            else if (unit >= THREE_BYTE_MIN) begin
                push_byte(PREFIX_THREE + 8'(unit[15:12]), 1'b0);
                push_byte(PREFIX_CONT + 8'(unit[11:6]), 1'b0);
                push_byte(PREFIX_CONT + 8'(unit[5:0]), 1'b1);
            end
            else if (unit >= TWO_BYTE_MIN) begin
                push_byte(PREFIX_TWO + 8'(unit[10:6]), 1'b0);
                push_byte(PREFIX_CONT + 8'(unit[5:0]), 1'b1);
            end
            else
            begin
                push_byte({1'b0, unit[6:0]}, 1'b1);
            end
            // End of string drops any held lead
            if (end_of_string)
                lead_held = 1'b0;
        endfunction

        // Compare an accepted byte with the oldest expected one
        function void check_byte(logic [7:0] octet, logic is_last);
            utf8_out_t want;
            n_bytes++;
            if (bytes_due.size() == 0) begin
                $display("%0t: unexpected byte: expected none, actual %02h last %b",
                         $time, octet, is_last);
                n_errors++;
                return;
            end
            want = bytes_due.pop_front();
            if (octet !== want.octet) begin
                $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                         $time, want.octet, octet);
                n_errors++;
            end
            if (is_last !== want.is_last) begin
                $display("%0t: last_byte mismatch: expected %b, actual %b",
                         $time, want.is_last, is_last);
                n_errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    u2u8_unit_if unit_chan ();
    u2u8_byte_if byte_chan ();

    utf8_scoreboard sb = new();

    // Idle percentages for the current phase and the receiver hold counter
    int send_idle;
    int recv_stall;
    int hold_left;

    utf16_to_utf8_converter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .unit_chan (unit_chan),
        .byte_chan (byte_chan)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // Hard stop in case the converter hangs
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Byte receiver: check each accepted request, then pick ready for the
    // next cycle. A nonzero hold_left forces ready low while it counts down.
    // ------------------------------------------------------------------------
    initial
    begin
        byte_chan.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (byte_chan.valid && byte_chan.ready)
                sb.check_byte(byte_chan.out_byte, byte_chan.last_byte);
            if (hold_left > 0) begin
                hold_left--;
                byte_chan.ready <= 1'b0;
            end
            else
            begin
                byte_chan.ready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender: idle at random, then hold the request until it is accepted.
    // Valid stays high into the next request unless that one starts idle.
    // ------------------------------------------------------------------------
    task automatic send_unit(input logic [15:0] unit, input logic end_of_string);
        while ($urandom_range(99) < send_idle)
        begin
            unit_chan.valid <= 1'b0;
            @(posedge clk);
        end
        unit_chan.valid     <= 1'b1;
        unit_chan.code_unit <= unit;
        unit_chan.last_unit <= end_of_string;
        @(posedge clk);
        while (!unit_chan.ready)
            @(posedge clk);
        sb.note_unit(unit, end_of_string);
    endtask

    function automatic logic [15:0] random_lead();
        return 16'($urandom_range(LEAD_HI, LEAD_LO));
    endfunction

    function automatic logic [15:0] random_trail();
        return 16'($urandom_range(TRAIL_HI, TRAIL_LO));
    endfunction

    // Three-byte range on either side of the surrogate block
    function automatic logic [15:0] random_three();
        if ($urandom_range(1))
            return 16'($urandom_range(LEAD_LO - 1, THREE_BYTE_MIN));
        return 16'($urandom_range(16'hFFFF, TRAIL_HI + 1));
    endfunction

    // ------------------------------------------------------------------------
    // One random string: mostly well-formed pairs and BMP units, some noise.
    // The final unit carries last_unit; now and then a unit mid-way carries it too.
    // ------------------------------------------------------------------------
    task automatic send_random_string();
        int         len;
        int         pick;
        bit         end_flag;
        unit_kind_t kind;
        logic [15:0] lead;
        len = $urandom_range(8, 1);
        for (int i = 0; i < len; i++)
        begin
            end_flag = (i == len - 1) || ($urandom_range(99) < 4);
            pick = $urandom_range(99);
            if (pick < 20)
                kind = KIND_ASCII;
            else if (pick < 35)
                kind = KIND_TWO;
            else if (pick < 50)
                kind = KIND_THREE;
            else if (pick < 85)
                kind = KIND_PAIR;
            else if (pick < 90)
                kind = KIND_LONE_TRAIL;
            else if (pick < 95)
                kind = KIND_LONE_LEAD;
            else
                kind = KIND_DOUBLE_LEAD;
            case (kind)
                KIND_ASCII:
                    send_unit(16'($urandom_range(TWO_BYTE_MIN - 1, 0)), end_flag);
                KIND_TWO:
                    send_unit(16'($urandom_range(THREE_BYTE_MIN - 1, TWO_BYTE_MIN)),
                              end_flag);
                KIND_THREE:
                    send_unit(random_three(), end_flag);
                KIND_PAIR:
                begin
                    send_unit(random_lead(), 1'b0);
                    // Now and then slip a plain unit between lead and trail
                    if ($urandom_range(99) < 10)
                        send_unit(16'($urandom_range(TWO_BYTE_MIN - 1, 0)), 1'b0);
                    send_unit(random_trail(), end_flag);
                end
                KIND_LONE_TRAIL:
                    send_unit(random_trail(), end_flag);
                KIND_LONE_LEAD:
                    send_unit(random_lead(), end_flag);
                default:
                begin
                    lead = random_lead();
                    send_unit(lead, 1'b0);
                    send_unit(random_lead(), 1'b0);
                    send_unit(random_trail(), end_flag);
                end
            endcase
        end
    endtask

    // Advance random strings until the phase's count of useful units is met
    task automatic run_phase(input int idle_pct, input int stall_pct, input int goal);
        int target;
        send_idle  = idle_pct;
        recv_stall = stall_pct;
        target = (sb.n_units - sb.n_dropped) + goal;
        while ((sb.n_units - sb.n_dropped) < target)
            send_random_string();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int waited;
        rst_n               <= 1'b0;
        unit_chan.valid     <= 1'b0;
        unit_chan.code_unit <= '0;
        unit_chan.last_unit <= 1'b0;
        send_idle  = 0;
        recv_stall = 0;
        hold_left  = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: range boundaries of each byte count
        send_unit(16'h0000, 1'b0);
        send_unit(16'(TWO_BYTE_MIN - 1), 1'b0);
        send_unit(TWO_BYTE_MIN, 1'b0);
        send_unit(16'(THREE_BYTE_MIN - 1), 1'b0);
        send_unit(THREE_BYTE_MIN, 1'b0);
        send_unit(16'(LEAD_LO - 1), 1'b0);
        send_unit(16'(TRAIL_HI + 1), 1'b0);
        send_unit(16'hFFFF, 1'b1);
        // Lowest and highest surrogate pairs
        send_unit(LEAD_LO, 1'b0);
        send_unit(TRAIL_LO, 1'b0);
        send_unit(LEAD_HI, 1'b0);
        send_unit(TRAIL_HI, 1'b1);
        // Second lead drops the held one, so the trail is a lone trail
        send_unit(LEAD_LO, 1'b0);
        send_unit(LEAD_HI, 1'b0);
        send_unit(TRAIL_LO, 1'b0);
        // Lone trail with nothing held
        send_unit(16'hDDDD, 1'b0);
        // Plain unit between lead and trail keeps the lead held
        send_unit(16'hD83D, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'hDE00, 1'b0);
        // Lead marked last is discarded; the trail after it is dropped
        send_unit(16'hDBC0, 1'b1);
        send_unit(16'hDC01, 1'b0);
        // Trail marked last still completes its pair
        send_unit(16'hD801, 1'b0);
        send_unit(16'hDFFE, 1'b1);
        // Plain unit marked last clears a held lead
        send_unit(16'hDA55, 1'b0);
        send_unit(16'h07FF, 1'b1);

        // Back-pressure: stall the receiver while units keep coming so the
        // run queue fills and the converter drops its ready
        hold_left = 80;
        run_phase(0, 0, 14);

        run_phase(0, 0, 80);
        run_phase(73, 0, 90);
        run_phase(0, 73, 90);
        run_phase(37, 37, 90);

        unit_chan.valid <= 1'b0;

        // Drain all expected bytes, then let stray ones show up
        waited = 0;
        while (sb.bytes_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.bytes_due.size() != 0) begin
            $display("%0t: missing bytes: expected %02h last %b (%0d in all), actual none",
                     $time, sb.bytes_due[0].octet, sb.bytes_due[0].is_last,
                     sb.bytes_due.size());
            sb.n_errors++;
        end

        $display("Sent %0d code units (%0d surrogate pairs, %0d dropped), checked %0d bytes",
                 sb.n_units, sb.n_pairs, sb.n_dropped, sb.n_bytes);
        $display("Mixes: no idling, sender idle, receiver stall, both, and one long hold");

        if (sb.n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
